// ===== src/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned QUOT_W  = 8;
  localparam int unsigned NUM_W   = 2 * QUOT_W;
  localparam int unsigned DIV_STEPS = 2;

  localparam int signed HUE_SCALE     = 30;
  localparam int signed HUE_OFS_GREEN = 60;
  localparam int signed HUE_OFS_BLUE  = 120;
  localparam int signed HUE_WRAP      = 180;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue_half;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness_value;
  } hsv_t;

  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  // restoring divider lane: quotient bits shift into low as numerator bits shift out
  typedef struct packed {
    logic [QUOT_W-1:0] rem;
    logic [QUOT_W-1:0] low;
    logic [QUOT_W-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        hue;
    div_lane_t        sat;
    logic [PIX_W-1:0] value;
  } div_word_t;

  function automatic div_lane_t div_step(div_lane_t l);
    logic [QUOT_W:0] t;
    logic [QUOT_W:0] d;
    div_lane_t r;
    t = {l.rem, l.low[QUOT_W-1]};
    d = t - {1'b0, l.dvs};
    r = l;
    if (!d[QUOT_W]) begin
      r.rem = d[QUOT_W-1:0];
      r.low = {l.low[QUOT_W-2:0], 1'b1};
    end else begin
      r.rem = t[QUOT_W-1:0];
      r.low = {l.low[QUOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== src/rgbhsv_prep.sv =====
module rgbhsv_prep (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              offset,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgbhsv_pkg::pixel_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgbhsv_pkg::div_word_t   out_data
);
  import rgbhsv_pkg::*;

  // stage A: brightness adjust
  logic             a_valid;
  pixel_t           a_pix;
  // stage B: max / min / sector
  logic             b_valid;
  logic [PIX_W-1:0] b_max;
  logic [PIX_W-1:0] b_delta;
  logic signed [PIX_W:0] b_diff;
  sector_t          b_sec;
  // stage C: dividend setup
  logic             c_valid;
  div_word_t        c_word;

  logic a_ready, b_ready, c_ready;

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  function automatic logic [PIX_W-1:0] sat_add(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W] ? {PIX_W{1'b1}} : s[PIX_W-1:0];
  endfunction

  pixel_t a_pix_next;
  always_comb begin
    a_pix_next.blue  = sat_add(in_data.blue,  offset);
    a_pix_next.green = sat_add(in_data.green, offset);
    a_pix_next.red   = sat_add(in_data.red,   offset);
  end

  logic [PIX_W-1:0] max_next, min_next;
  logic signed [PIX_W:0] diff_next;
  sector_t sec_next;
  always_comb begin
    max_next = a_pix.red;
    min_next = a_pix.red;
    if (a_pix.green > max_next) max_next = a_pix.green;
    if (a_pix.blue  > max_next) max_next = a_pix.blue;
    if (a_pix.green < min_next) min_next = a_pix.green;
    if (a_pix.blue  < min_next) min_next = a_pix.blue;
    priority if (a_pix.red >= a_pix.green && a_pix.red >= a_pix.blue) begin
      sec_next  = SEC_RED;
      diff_next = $signed({1'b0, a_pix.green}) - $signed({1'b0, a_pix.blue});
    end else if (a_pix.green >= a_pix.blue) begin
      sec_next  = SEC_GREEN;
      diff_next = $signed({1'b0, a_pix.blue}) - $signed({1'b0, a_pix.red});
    end else begin
      sec_next  = SEC_BLUE;
      diff_next = $signed({1'b0, a_pix.red}) - $signed({1'b0, a_pix.green});
    end
  end

  logic signed [17:0] dx, ofs, num;
  logic [NUM_W-1:0]   sat_num;
  div_word_t          c_word_next;
  always_comb begin
    dx = $signed({10'b0, b_delta});
    unique case (b_sec)
      SEC_RED:   ofs = '0;
      SEC_GREEN: ofs = dx * 18'(HUE_OFS_GREEN);
      SEC_BLUE:  ofs = dx * 18'(HUE_OFS_BLUE);
      default:   ofs = '0;
    endcase
    num = 18'(b_diff) * 18'(HUE_SCALE) + ofs;
    if (num < 0) num = num + dx * 18'(HUE_WRAP);
    sat_num = {b_delta, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, b_delta};

    c_word_next.value = b_max;
    if (b_delta == '0) begin
      c_word_next.hue.rem = '0;
      c_word_next.hue.low = '0;
      c_word_next.hue.dvs = QUOT_W'(1);
    end else begin
      c_word_next.hue.rem = num[NUM_W-1:QUOT_W];
      c_word_next.hue.low = num[QUOT_W-1:0];
      c_word_next.hue.dvs = b_delta;
    end
    if (b_max == '0) begin
      c_word_next.sat.rem = '0;
      c_word_next.sat.low = '0;
      c_word_next.sat.dvs = QUOT_W'(1);
    end else begin
      c_word_next.sat.rem = sat_num[NUM_W-1:QUOT_W];
      c_word_next.sat.low = sat_num[QUOT_W-1:0];
      c_word_next.sat.dvs = b_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) a_pix <= a_pix_next;
    if (b_ready && a_valid) begin
      b_max   <= max_next;
      b_delta <= max_next - min_next;
      b_diff  <= diff_next;
      b_sec   <= sec_next;
    end
    if (c_ready && b_valid) c_word <= c_word_next;
  end

  assign out_valid = c_valid;
  assign out_data  = c_word;

endmodule

// ===== src/rgbhsv_div_pipe.sv =====
module rgbhsv_div_pipe #(
  parameter int unsigned STEPS_PER_STAGE = rgbhsv_pkg::DIV_STEPS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgbhsv_pkg::div_word_t   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgbhsv_pkg::hsv_t        out_data
);
  import rgbhsv_pkg::*;

  localparam int unsigned STAGES = QUOT_W / STEPS_PER_STAGE;

  logic [STAGES-1:0] valid;
  logic [STAGES:0]   ready;
  div_word_t         stage_q   [STAGES];
  div_word_t         stage_in  [STAGES];
  div_word_t         stage_out [STAGES];

  assign ready[STAGES] = out_ready;
  assign in_ready      = ready[0];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign stage_in[i] = in_data;
    end else begin : g_rest
      assign stage_in[i] = stage_q[i-1];
    end

    logic up_valid;
    if (i == 0) begin : g_v0
      assign up_valid = in_valid;
    end else begin : g_vn
      assign up_valid = valid[i-1];
    end

    assign ready[i] = !valid[i] || ready[i+1];

    always_comb begin
      div_word_t w;
      w = stage_in[i];
      for (int s = 0; s < int'(STEPS_PER_STAGE); s++) begin
        w.hue = div_step(w.hue);
        w.sat = div_step(w.sat);
      end
      stage_out[i] = w;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (ready[i]) begin
        valid[i] <= up_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[i] && up_valid) stage_q[i] <= stage_out[i];
    end
  end

  assign out_valid                 = valid[STAGES-1];
  assign out_data.hue_half         = stage_q[STAGES-1].hue.low;
  assign out_data.saturation       = stage_q[STAGES-1].sat.low;
  assign out_data.brightness_value = stage_q[STAGES-1].value;

endmodule

// ===== src/rgb_to_hsv_8bit.sv =====
// Throughput: one word per cycle unless hsv_stall holds the output; each stage
// holds one word and moves on when the next stage frees, so the two dividers
// (DIV_STEPS_PER_STAGE quotient bits per stage) set the depth but not the rate.
// Reset (rst, synchronous): clears all stage valids and brightness_offset to 0.
module rgb_to_hsv_8bit #(
  parameter int unsigned DIV_STEPS_PER_STAGE = rgbhsv_pkg::DIV_STEPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  rgbhsv_pkg::pixel_t  pix,
  output logic                hsv_valid,
  input  logic                hsv_stall,
  output rgbhsv_pkg::hsv_t    hsv,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import rgbhsv_pkg::*;

  logic [PIX_W-1:0] brightness_offset;
  logic             pre_ready;
  logic             mid_valid;
  logic             mid_ready;
  div_word_t        mid_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      brightness_offset <= cfg_data;
    end
  end

  assign pix_stall = !pre_ready;

  rgbhsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .offset    (brightness_offset),
    .in_valid  (pix_valid),
    .in_ready  (pre_ready),
    .in_data   (pix),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_word)
  );

  rgbhsv_div_pipe #(
    .STEPS_PER_STAGE (DIV_STEPS_PER_STAGE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_word),
    .out_valid (hsv_valid),
    .out_ready (!hsv_stall),
    .out_data  (hsv)
  );

endmodule

// ===== src/rgbhsv_checker.sv =====
module rgbhsv_checker (
  input logic             clk,
  input logic             rst,
  input logic             hsv_valid,
  input logic             hsv_stall,
  input rgbhsv_pkg::hsv_t hsv
);
  import rgbhsv_pkg::*;

  // held word must not change under stall
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv_stall |=> hsv_valid && $stable(hsv))
    else $error("output word changed while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue_half <= 8'd179)
    else $error("hue out of range");

  // grey pixels: zero saturation means zero hue
  a_grey: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.saturation == '0 |-> hsv.hue_half == '0)
    else $error("nonzero hue on grey pixel");

  a_black: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.brightness_value == '0 |-> hsv.saturation == '0)
    else $error("nonzero saturation on black pixel");

endmodule

bind rgb_to_hsv_8bit rgbhsv_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .hsv_valid (hsv_valid),
  .hsv_stall (hsv_stall),
  .hsv       (hsv)
);

// ===== bench/hsv_checker.sv =====
`timescale 1ns / 1ps

module hsv_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  input  logic               pix_stall,
  input  rgbhsv_pkg::pixel_t pix,
  input  logic               hsv_valid,
  input  logic               hsv_stall,
  input  rgbhsv_pkg::hsv_t   hsv,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 mismatch_count,
  output int                 hsv_outstanding
);
  import rgbhsv_pkg::*;

  hsv_t       expected_hsv_q[$];
  logic [7:0] offset_copy = 8'd0;
  int         errs = 0;

  function automatic int clamp_sum(logic [7:0] a, logic [7:0] ofs);
    int s;
    s = int'(a) + int'(ofs);
    return (s > 255) ? 255 : s;
  endfunction

  function automatic hsv_t predict_hsv(pixel_t p, logic [7:0] ofs);
    int      b, g, r, mx, mn, delta, num, hue;
    sector_t sector;
    hsv_t    res;
    b = clamp_sum(p.blue, ofs);
    g = clamp_sum(p.green, ofs);
    r = clamp_sum(p.red, ofs);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    res = '0;
    res.brightness_value = 8'(mx);
    if (mx != 0) begin
      res.saturation = 8'((255 * delta) / mx);
      if (delta != 0) begin
        // red wins ties, then green
        if (r == mx) sector = SEC_RED;
        else if (g == mx) sector = SEC_GREEN;
        else sector = SEC_BLUE;
        case (sector)
          SEC_RED:   num = HUE_SCALE * (g - b);
          SEC_GREEN: num = HUE_SCALE * (b - r) + HUE_OFS_GREEN * delta;
          default:   num = HUE_SCALE * (r - g) + HUE_OFS_BLUE * delta;
        endcase
        if (num < 0) num += HUE_WRAP * delta;
        hue = num / delta;
        if (hue > 179) hue = 179;
        res.hue_half = 8'(hue);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    if (rst) begin
      offset_copy = 8'd0;
      expected_hsv_q.delete();
    end else begin
      if (hsv_valid && !hsv_stall) begin
        if (expected_hsv_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected hsv word h=%0d s=%0d v=%0d", $realtime,
                     hsv.hue_half, hsv.saturation, hsv.brightness_value);
          errs++;
        end else begin
          want = expected_hsv_q.pop_front();
          if (hsv.hue_half !== want.hue_half || hsv.saturation !== want.saturation ||
              hsv.brightness_value !== want.brightness_value) begin
            if (errs < 10)
              $display("%0t: hsv mismatch exp h=%0d s=%0d v=%0d got h=%0d s=%0d v=%0d",
                       $realtime, want.hue_half, want.saturation, want.brightness_value,
                       hsv.hue_half, hsv.saturation, hsv.brightness_value);
            errs++;
          end
        end
      end
      if (pix_valid && !pix_stall) expected_hsv_q.push_back(predict_hsv(pix, offset_copy));
      if (cfg_valid && cfg_ready) offset_copy = cfg_data;
    end
    mismatch_count  <= errs;
    hsv_outstanding <= expected_hsv_q.size();
  end

endmodule

// ===== bench/rgb_to_hsv_8bit_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_8bit_tb;
  import rgbhsv_pkg::*;

  localparam int ITEMS_PER_PHASE = 220;
  localparam int NUM_PHASES      = 8;
  localparam int DRAIN_CYCLES    = 12;
  localparam int IDLE_LIMIT      = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       pix_valid = 1'b0;
  logic       pix_stall;
  pixel_t     pix = '0;
  logic       hsv_valid;
  logic       hsv_stall = 1'b0;
  hsv_t       hsv;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  int mismatch_count;
  int hsv_outstanding;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  rgb_to_hsv_8bit dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  hsv_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .pix_valid       (pix_valid),
    .pix_stall       (pix_stall),
    .pix             (pix),
    .hsv_valid       (hsv_valid),
    .hsv_stall       (hsv_stall),
    .hsv             (hsv),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .hsv_outstanding (hsv_outstanding)
  );

  // receiver stall pattern: free, light, heavy, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0:       hsv_stall <= 1'b0;
      1:       hsv_stall <= ($urandom_range(0, 3) == 0);
      2:       hsv_stall <= ($urandom_range(0, 3) != 0);
      default: hsv_stall <= stall_tick[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (hsv_valid && !hsv_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("rgb_to_hsv_8bit verification failed");
        $finish;
      end
    end
  end

  function automatic pixel_t mk(int b, int g, int r);
    return '{blue: 8'(b), green: 8'(g), red: 8'(r)};
  endfunction

  function automatic pixel_t pick_pixel(logic [7:0] ofs);
    int c[3];
    int base, j, v;
    base = $urandom_range(0, 255);
    for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: begin
        c[0] = base;
        c[1] = base;
        c[2] = base;
      end
      1: begin
        j = $urandom_range(0, 2);
        c[j] = base;
        c[(j + 1) % 3] = base;
        c[(j + 2) % 3] = $urandom_range(0, base);
      end
      2: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 4))
            0: c[i] = 0;
            1: c[i] = 1;
            2: c[i] = 254;
            3: c[i] = 255;
            default: ;
          endcase
        end
      end
      3: begin
        // channels around the brightness clip point
        for (int i = 0; i < 3; i++) begin
          v = 255 - int'(ofs) + $urandom_range(0, 4) - 2;
          c[i] = (v < 0) ? 0 : (v > 255) ? 255 : v;
        end
      end
      default: ;
    endcase
    return mk(c[0], c[1], c[2]);
  endfunction

  task automatic send_pixel(input pixel_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix       <= p;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (hsv_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(input logic [7:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] phase_ofs [NUM_PHASES];
    phase_ofs = '{8'd255, 8'd1, 8'd254, 8'd128, 8'($urandom_range(0, 40)),
                  8'($urandom_range(0, 255)), 8'd0, 8'($urandom_range(0, 16))};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_offset(8'd0);
    // directed words: blue, green, red
    send_pixel(mk(0, 0, 0));        // black
    send_pixel(mk(255, 255, 255));  // white
    send_pixel(mk(128, 128, 128));  // grey
    send_pixel(mk(0, 0, 255));
    send_pixel(mk(0, 255, 0));
    send_pixel(mk(255, 0, 0));
    send_pixel(mk(0, 255, 255));    // red/green tie
    send_pixel(mk(255, 255, 0));    // green/blue tie
    send_pixel(mk(255, 0, 255));    // red/blue tie
    send_pixel(mk(100, 0, 255));    // red sector wraps
    send_pixel(mk(1, 0, 255));      // top of hue range
    send_pixel(mk(0, 1, 255));
    send_pixel(mk(0, 100, 255));
    send_pixel(mk(0, 200, 100));
    send_pixel(mk(200, 0, 100));
    send_pixel(mk(0, 0, 1));
    send_pixel(mk(1, 1, 0));
    send_pixel(mk(254, 255, 253));
    send_pixel(mk(0, 254, 255));
    send_pixel(mk(1, 2, 3));
    send_pixel(mk(170, 85, 0));
    send_pixel(mk(255, 1, 254));
    wait_drained();

    write_offset(8'd200);
    send_pixel(mk(100, 0, 60));     // clipped channels
    send_pixel(mk(55, 54, 0));
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_offset(phase_ofs[ph]);
      repeat (ITEMS_PER_PHASE) send_pixel(pick_pixel(phase_ofs[ph]));
      wait_drained();
    end

    if (mismatch_count == 0 && hsv_outstanding == 0) begin
      $display("rgb_to_hsv_8bit verification clean");
    end else begin
      $display("rgb_to_hsv_8bit verification failed");
    end
    $finish;
  end

endmodule
